// ===== design/assert_macros.svh =====
// assertion macros shared by the generator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check that is held off while reset is high
`define MTG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define MTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mtg_pkg.sv =====
// types, constants and word functions of the mt19937 generator
// no dependencies; used by the top level
package mtg_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned SHIFT_DIST  = 397;

  localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT   = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS   = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [31:0] MUL_INIT   = 32'd1812433253;
  localparam logic [31:0] MUL_ARR1   = 32'd1664525;
  localparam logic [31:0] MUL_ARR2   = 32'd1566083941;
  localparam logic [31:0] SEED_ARRAY = 32'd19650218;
  localparam logic [31:0] SEED_AUTO  = 32'd5489;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FULL_IDX   = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] UNSEEDED   = IDX_W'(STATE_WORDS + 1);

  typedef enum logic [1:0] {
    FUNC_NEXT   = 2'd0,
    FUNC_RESEED = 2'd1,
    FUNC_KEY    = 2'd2,
    FUNC_ALIAS  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RES_WORD     = 2'd0,
    RES_RESEEDED = 2'd1,
    RES_STORED   = 2'd2,
    RES_FULL     = 2'd3
  } result_t;

  // where linear seeding goes when it finishes
  typedef enum logic [1:0] {
    RET_RESEED,
    RET_TWIST,
    RET_ARRAY
  } ret_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LS_START,
    ST_LS_MUL,
    ST_LS_WR,
    ST_TW_A,
    ST_TW_B,
    ST_TW_F,
    ST_TW_WR,
    ST_OUT_RD,
    ST_OUT_TMP,
    ST_A1_RP,
    ST_A1_RC,
    ST_A1_WR,
    ST_A1_WRAP,
    ST_A2_RP,
    ST_A2_RC,
    ST_A2_WR,
    ST_A2_WRAP,
    ST_FIX
  } state_t;

  // previous word folded with its top bits, ahead of the multiply
  function automatic logic [31:0] mix(input logic [31:0] x);
    return x ^ (x >> 30);
  endfunction

  // one step of the state recurrence
  function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] far);
    logic [31:0] y;
    y = (a & HIGH_BIT) | (b & LOW_BITS);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
  endfunction

  // output tempering
  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

endpackage

// ===== design/mtg_req_if.sv =====
// request channel of the generator: function code and key word
// depends on nothing but the port widths of the generator
interface mtg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] key_word;
  logic        key_last;

  modport source (output valid, output func, output key_word, output key_last, input ready);
  modport sink   (input valid, input func, input key_word, input key_last, output ready);
endinterface

// ===== design/mtg_rsp_if.sv =====
// response channel of the generator: random word and result code
// depends on nothing but the port widths of the generator
interface mtg_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  logic [1:0]  result_code;

  modport source (output valid, output random_word, output result_code, input ready);
  modport sink   (input valid, input random_word, input result_code, output ready);
endinterface

// ===== design/mersenne_twister_generator.sv =====
// mt19937 top level: sequencer, 624-word state memory, key store memory
// depends on mtg_pkg, mtg_req_if, mtg_rsp_if, mtg_mul and assert_macros.svh
//
// One request in, one response out. The 624-word state sits in a memory
// with one write port and one registered read port, and one shared
// multiplier serves all seeding math; the block takes one request at a time.
// A plain next-word request passes a read state and a tempering state; the
// response is then held until the receiver takes it, and no new request is
// accepted before that. Every 624th word first runs the full twist over all
// state words, and a word asked for before any seeding first runs linear
// seeding from 5489. Reseed (func 1) runs linear seeding from the cfg seed.
// A key word without the last mark answers at once; with it, array seeding
// runs linear seeding, then passes of 624 and 623 steps plus wrap steps.
// The memory is never cleared; every word is written by seeding before use.
module mersenne_twister_generator #(
  parameter int unsigned MAX_KEY_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  mtg_req_if.sink     req,
  mtg_rsp_if.source   rsp
);

  localparam int unsigned KCW = $clog2(MAX_KEY_WORDS + 1);
  localparam int unsigned KIW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam logic [KCW-1:0] KEY_MAX = KCW'(MAX_KEY_WORDS);
  localparam int unsigned IW = mtg_pkg::IDX_W;

  mtg_pkg::state_t state, state_next;
  mtg_pkg::ret_t   ret, ret_next;
  mtg_pkg::result_t code_pend, code_pend_next, out_code, out_code_next;

  logic [IW-1:0]  ctr, ctr_next;
  logic [IW-1:0]  kcnt, kcnt_next;
  logic [IW-1:0]  word_index, word_index_next;
  logic [KIW-1:0] j, j_next;
  logic [KCW-1:0] len, len_next;
  logic [KCW-1:0] key_count, key_count_next;
  logic [31:0]    seed, lseed, lseed_next;
  logic [31:0]    hold_a, hold_a_next, hold_b, hold_b_next;
  logic           out_valid, out_set;
  logic [31:0]    out_word, out_word_next;

  logic [31:0]    mem [mtg_pkg::STATE_WORDS];
  logic           we;
  logic [IW-1:0]  waddr, raddr;
  logic [31:0]    wdata, rdata;

  logic [31:0]    key_mem [MAX_KEY_WORDS];
  logic           key_we;
  logic [31:0]    key_rdata;

  logic [31:0]    mul_a, mul_b, prod;
  logic [IW-1:0]  nx, fr;
  logic [IW:0]    fr_sum;
  logic [KCW-1:0] j_inc;
  logic [31:0]    v;
  logic           accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == mtg_pkg::ST_IDLE) && !out_valid;
  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;
  assign rsp.result_code = out_code;

  // neighbor and far indexes of the twist
  assign nx     = (ctr == mtg_pkg::LAST_IDX) ? '0 : ctr + 1'b1;
  assign fr_sum = {1'b0, ctr} + (IW + 1)'(mtg_pkg::SHIFT_DIST);
  assign fr     = (fr_sum >= (IW + 1)'(mtg_pkg::STATE_WORDS))
                  ? IW'(fr_sum - (IW + 1)'(mtg_pkg::STATE_WORDS)) : fr_sum[IW-1:0];
  assign j_inc  = KCW'(j) + 1'b1;

  // shared multiplier operands
  always_comb begin
    mul_a = mtg_pkg::mix((state == mtg_pkg::ST_LS_MUL) ? hold_a : rdata);
    unique case (state)
      mtg_pkg::ST_A1_RC: mul_b = mtg_pkg::MUL_ARR1;
      mtg_pkg::ST_A2_RC: mul_b = mtg_pkg::MUL_ARR2;
      default:           mul_b = mtg_pkg::MUL_INIT;
    endcase
  end

  mtg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // state memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // key store memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count[KIW-1:0]] <= req.key_word;
    end
    key_rdata <= key_mem[j];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mtg_pkg::ST_IDLE;
      seed       <= mtg_pkg::SEED_AUTO;
      word_index <= mtg_pkg::UNSEEDED;
      key_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      word_index <= word_index_next;
      key_count  <= key_count_next;
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ret       <= ret_next;
    code_pend <= code_pend_next;
    ctr       <= ctr_next;
    kcnt      <= kcnt_next;
    j         <= j_next;
    len       <= len_next;
    lseed     <= lseed_next;
    hold_a    <= hold_a_next;
    hold_b    <= hold_b_next;
    if (out_set) begin
      out_word <= out_word_next;
      out_code <= out_code_next;
    end
  end

  // next state and datapath control
  always_comb begin
    state_next      = state;
    ret_next        = ret;
    code_pend_next  = code_pend;
    ctr_next        = ctr;
    kcnt_next       = kcnt;
    j_next          = j;
    len_next        = len;
    key_count_next  = key_count;
    word_index_next = word_index;
    lseed_next      = lseed;
    hold_a_next     = hold_a;
    hold_b_next     = hold_b;
    out_set         = 1'b0;
    out_word_next   = '0;
    out_code_next   = mtg_pkg::RES_WORD;
    we              = 1'b0;
    waddr           = ctr;
    wdata           = '0;
    raddr           = ctr;
    key_we          = 1'b0;
    v               = '0;

    unique case (state)
      mtg_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mtg_pkg::func_t'(req.func))
            mtg_pkg::FUNC_RESEED: begin
              lseed_next = seed;
              ret_next   = mtg_pkg::RET_RESEED;
              state_next = mtg_pkg::ST_LS_START;
            end
            mtg_pkg::FUNC_KEY: begin
              if (key_count != KEY_MAX) begin
                key_we         = 1'b1;
                key_count_next = key_count + 1'b1;
                out_code_next  = mtg_pkg::RES_STORED;
              end else begin
                out_code_next  = mtg_pkg::RES_FULL;
              end
              if (req.key_last) begin
                len_next       = key_count_next;
                key_count_next = '0;
                code_pend_next = out_code_next;
                lseed_next     = mtg_pkg::SEED_ARRAY;
                ret_next       = mtg_pkg::RET_ARRAY;
                state_next     = mtg_pkg::ST_LS_START;
              end else begin
                out_set = 1'b1;
              end
            end
            default: begin
              if (word_index >= mtg_pkg::FULL_IDX) begin
                if (word_index != mtg_pkg::FULL_IDX) begin
                  lseed_next = mtg_pkg::SEED_AUTO;
                  ret_next   = mtg_pkg::RET_TWIST;
                  state_next = mtg_pkg::ST_LS_START;
                end else begin
                  ctr_next   = '0;
                  state_next = mtg_pkg::ST_TW_A;
                end
              end else begin
                ctr_next   = word_index;
                state_next = mtg_pkg::ST_OUT_RD;
              end
            end
          endcase
        end
      end

      // linear seeding: word 0 then one multiply and write per word
      mtg_pkg::ST_LS_START: begin
        we          = 1'b1;
        waddr       = '0;
        wdata       = lseed;
        hold_a_next = lseed;
        ctr_next    = IW'(1);
        state_next  = mtg_pkg::ST_LS_MUL;
      end
      mtg_pkg::ST_LS_MUL: begin
        state_next = mtg_pkg::ST_LS_WR;
      end
      mtg_pkg::ST_LS_WR: begin
        v           = prod + 32'(ctr);
        we          = 1'b1;
        wdata       = v;
        hold_a_next = v;
        if (ctr == mtg_pkg::LAST_IDX) begin
          word_index_next = mtg_pkg::FULL_IDX;
          unique case (ret)
            mtg_pkg::RET_RESEED: begin
              out_set       = 1'b1;
              out_code_next = mtg_pkg::RES_RESEEDED;
              state_next    = mtg_pkg::ST_IDLE;
            end
            mtg_pkg::RET_TWIST: begin
              ctr_next   = '0;
              state_next = mtg_pkg::ST_TW_A;
            end
            default: begin
              ctr_next   = IW'(1);
              j_next     = '0;
              kcnt_next  = mtg_pkg::FULL_IDX;
              state_next = mtg_pkg::ST_A1_RP;
            end
          endcase
        end else begin
          ctr_next   = ctr + 1'b1;
          state_next = mtg_pkg::ST_LS_MUL;
        end
      end

      // twist: read own, next and far word, then write back
      mtg_pkg::ST_TW_A: begin
        state_next = mtg_pkg::ST_TW_B;
      end
      mtg_pkg::ST_TW_B: begin
        raddr       = nx;
        hold_a_next = rdata;
        state_next  = mtg_pkg::ST_TW_F;
      end
      mtg_pkg::ST_TW_F: begin
        raddr       = fr;
        hold_b_next = rdata;
        state_next  = mtg_pkg::ST_TW_WR;
      end
      mtg_pkg::ST_TW_WR: begin
        we    = 1'b1;
        wdata = mtg_pkg::twist(hold_a, hold_b, rdata);
        if (ctr == mtg_pkg::LAST_IDX) begin
          word_index_next = '0;
          ctr_next        = '0;
          state_next      = mtg_pkg::ST_OUT_RD;
        end else begin
          ctr_next   = ctr + 1'b1;
          state_next = mtg_pkg::ST_TW_A;
        end
      end

      // word output
      mtg_pkg::ST_OUT_RD: begin
        state_next = mtg_pkg::ST_OUT_TMP;
      end
      mtg_pkg::ST_OUT_TMP: begin
        out_set         = 1'b1;
        out_word_next   = mtg_pkg::temper(rdata);
        out_code_next   = mtg_pkg::RES_WORD;
        word_index_next = ctr + 1'b1;
        state_next      = mtg_pkg::ST_IDLE;
      end

      // array seeding, first pass mixes in the key
      mtg_pkg::ST_A1_RP: begin
        raddr      = ctr - 1'b1;
        state_next = mtg_pkg::ST_A1_RC;
      end
      mtg_pkg::ST_A1_RC: begin
        state_next = mtg_pkg::ST_A1_WR;
      end
      mtg_pkg::ST_A1_WR: begin
        v           = (rdata ^ prod) + key_rdata + 32'(j);
        we          = 1'b1;
        wdata       = v;
        hold_b_next = v;
        kcnt_next   = kcnt - 1'b1;
        j_next      = (j_inc >= len) ? '0 : j_inc[KIW-1:0];
        if (ctr == mtg_pkg::LAST_IDX) begin
          state_next = mtg_pkg::ST_A1_WRAP;
        end else begin
          ctr_next = ctr + 1'b1;
          if (kcnt_next == '0) begin
            kcnt_next  = mtg_pkg::LAST_IDX;
            state_next = mtg_pkg::ST_A2_RP;
          end else begin
            state_next = mtg_pkg::ST_A1_RP;
          end
        end
      end
      mtg_pkg::ST_A1_WRAP: begin
        we       = 1'b1;
        waddr    = '0;
        wdata    = hold_b;
        ctr_next = IW'(1);
        if (kcnt == '0) begin
          kcnt_next  = mtg_pkg::LAST_IDX;
          state_next = mtg_pkg::ST_A2_RP;
        end else begin
          state_next = mtg_pkg::ST_A1_RP;
        end
      end

      // array seeding, second pass
      mtg_pkg::ST_A2_RP: begin
        raddr      = ctr - 1'b1;
        state_next = mtg_pkg::ST_A2_RC;
      end
      mtg_pkg::ST_A2_RC: begin
        state_next = mtg_pkg::ST_A2_WR;
      end
      mtg_pkg::ST_A2_WR: begin
        v           = (rdata ^ prod) - 32'(ctr);
        we          = 1'b1;
        wdata       = v;
        hold_b_next = v;
        kcnt_next   = kcnt - 1'b1;
        if (ctr == mtg_pkg::LAST_IDX) begin
          state_next = mtg_pkg::ST_A2_WRAP;
        end else begin
          ctr_next   = ctr + 1'b1;
          state_next = (kcnt_next == '0) ? mtg_pkg::ST_FIX : mtg_pkg::ST_A2_RP;
        end
      end
      mtg_pkg::ST_A2_WRAP: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = hold_b;
        ctr_next   = IW'(1);
        state_next = (kcnt == '0) ? mtg_pkg::ST_FIX : mtg_pkg::ST_A2_RP;
      end

      // word 0 fixed to the high bit, respond with stored key status
      mtg_pkg::ST_FIX: begin
        we              = 1'b1;
        waddr           = '0;
        wdata           = mtg_pkg::HIGH_BIT;
        word_index_next = mtg_pkg::FULL_IDX;
        out_set         = 1'b1;
        out_code_next   = code_pend;
        state_next      = mtg_pkg::ST_IDLE;
      end

      default: begin
        state_next = mtg_pkg::ST_IDLE;
      end
    endcase
  end

`include "assert_macros.svh"

  `MTG_ASSERT(a_index_range, clk, rst, word_index <= mtg_pkg::UNSEEDED, "word index out of range")
  `MTG_ASSERT(a_key_count, clk, rst, key_count <= KEY_MAX, "key count beyond store depth")
  `MTG_ASSERT(a_twist_idx, clk, rst, (state == mtg_pkg::ST_TW_WR) |-> (ctr <= mtg_pkg::LAST_IDX), "twist index beyond state")
  `MTG_ASSERT(a_fix_idx, clk, rst, (state == mtg_pkg::ST_FIX) |=> (word_index == mtg_pkg::FULL_IDX), "seeding did not arm twist")
  `MTG_ASSERT_ALWAYS(a_busy_block, clk, (state != mtg_pkg::ST_IDLE) |-> !req.ready, "request taken while busy")

endmodule

// ===== design/mtg_mul.sv =====
// shared 32x32 multiplier of the generator, low word kept, product registered
// no package use; instantiated by mersenne_twister_generator
module mtg_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [31:0] full;

  // low word of the product, registered
  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full;
  end

endmodule
